// ===== design/tfz_pkg.sv =====
// Shared types and constants of the seven-set triangular fuzzifier.
// Holds the class record passed from the front end to the divider back end.
// No dependencies.
`default_nettype none

package tfz_pkg;

	localparam int SET_COUNT         = 7;
	localparam int IDX_W             = 3;
	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int FRAC_BITS_DEF     = 15;
	localparam int QUEUE_DEPTH       = 2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_BREAK_NB = 3'd0;
	localparam logic [IDX_W-1:0] REG_BREAK_NM = 3'd1;
	localparam logic [IDX_W-1:0] REG_BREAK_NS = 3'd2;
	localparam logic [IDX_W-1:0] REG_BREAK_ZZ = 3'd3;
	localparam logic [IDX_W-1:0] REG_BREAK_PS = 3'd4;
	localparam logic [IDX_W-1:0] REG_BREAK_PM = 3'd5;
	localparam logic [IDX_W-1:0] REG_BREAK_PB = 3'd6;

	typedef enum logic [1:0] {
		KIND_NB_FULL = 2'd0,
		KIND_PB_FULL = 2'd1,
		KIND_SPAN    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [IDX_W-1:0] idx;
	} cls_t;

	// reset peaks sit at (i - 3) eighths of full scale
	function automatic int break_reset(input int i, input int sw);
		return (i - 3) * (1 << (sw - 3));
	endfunction

endpackage

`default_nettype wire

// ===== design/tfz_fifo.sv =====
// Small first-word-fall-through queue built from flip-flops.
// Used between front end and back end, and as the result queue.
// Depends on nothing.
`default_nettype none

module tfz_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== design/tfz_front.sv =====
// Front end: breakpoint registers, sample intake and interval classification.
// Emits a class record with the interval ends; uses tfz_pkg.
`default_nettype none

module tfz_front #(
	parameter int SAMPLE_WIDTH = tfz_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_value,
	output logic                                full,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tfz_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [SAMPLE_WIDTH-1:0]        cfg_data,
	input  wire logic                           mid_full,
	output logic                                mid_push,
	output tfz_pkg::cls_t                       cls,
	output logic signed [SAMPLE_WIDTH-1:0]      x,
	output logic signed [SAMPLE_WIDTH-1:0]      lo,
	output logic signed [SAMPLE_WIDTH-1:0]      hi
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int NS = tfz_pkg::SET_COUNT;

	logic signed [SW-1:0]           breaks_q [NS];
	logic [NS-1:0]                  ge;
	logic                           le_first;
	logic                           found;
	logic [tfz_pkg::IDX_W-1:0]      sel;
	tfz_pkg::cls_t                  cls_c;
	logic                           accept;

	logic                           v_s1;
	tfz_pkg::cls_t                  cls_s1;
	logic signed [SW-1:0]           x_s1;
	logic signed [SW-1:0]           lo_s1;
	logic signed [SW-1:0]           hi_s1;

	assign cfg_ready = 1'b1;
	assign full      = v_s1 && mid_full;
	assign accept    = push && !full;
	assign mid_push  = v_s1 && !mid_full;
	assign cls       = cls_s1;
	assign x         = x_s1;
	assign lo        = lo_s1;
	assign hi        = hi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				breaks_q[i] <= SW'(tfz_pkg::break_reset(i, SW));
			end
		end else if (cfg_valid && cfg_index <= tfz_pkg::REG_BREAK_PB) begin
			breaks_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			ge[i] = (sample_value >= breaks_q[i]);
		end
		le_first = (sample_value <= breaks_q[0]);
	end

	// lowest interval with lo <= x < hi wins
	always_comb begin
		found = 1'b0;
		sel   = '0;
		for (int i = NS - 2; i >= 0; i--) begin
			if (ge[i] && !ge[i+1]) begin
				found = 1'b1;
				sel   = tfz_pkg::IDX_W'(i);
			end
		end
		cls_c.idx = sel;
		if (le_first) begin
			cls_c.kind = tfz_pkg::KIND_NB_FULL;
		end else if (found) begin
			cls_c.kind = tfz_pkg::KIND_SPAN;
		end else begin
			cls_c.kind = tfz_pkg::KIND_PB_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (mid_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1 <= cls_c;
			x_s1   <= sample_value;
			lo_s1  <= breaks_q[sel];
			hi_s1  <= breaks_q[tfz_pkg::IDX_W'(sel + 1'b1)];
		end
	end

endmodule

`default_nettype wire

// ===== design/tfz_back.sv =====
// Back end: distance stage, two pipelined restoring dividers (one quotient
// bit per stage) and assembly of the seven degrees; uses tfz_pkg.
`default_nettype none

module tfz_back #(
	parameter int SAMPLE_WIDTH = tfz_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = tfz_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          mid_empty,
	output logic                                               mid_pop,
	input  wire tfz_pkg::cls_t                                 cls,
	input  wire logic signed [SAMPLE_WIDTH-1:0]                x,
	input  wire logic signed [SAMPLE_WIDTH-1:0]                lo,
	input  wire logic signed [SAMPLE_WIDTH-1:0]                hi,
	input  wire logic                                          out_full,
	output logic                                               out_push,
	output logic [tfz_pkg::SET_COUNT-1:0][FRAC_BITS:0]         out_data
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int NS = tfz_pkg::SET_COUNT;
	localparam int NSTG = FB + 1;

	logic                 en;
	logic signed [SW:0]   up_w;
	logic signed [SW:0]   dn_w;
	logic signed [SW:0]   d_w;

	logic                 v_s0;
	tfz_pkg::cls_t        cls_s0;
	logic [SW-1:0]        up_s0;
	logic [SW-1:0]        dn_s0;
	logic [SW-1:0]        d_s0;

	logic                 v_sd   [NSTG];
	tfz_pkg::cls_t        cls_sd [NSTG];
	logic [FB:0]          qup_sd [NSTG];
	logic [FB:0]          qdn_sd [NSTG];
	logic [SW-1:0]        rup_sd [FB];
	logic [SW-1:0]        rdn_sd [FB];
	logic [SW-1:0]        d_sd   [FB];

	// whole back end moves together; result queue full freezes it
	assign en      = !out_full;
	assign mid_pop = en && !mid_empty;

	assign up_w = {x[SW-1], x} - {lo[SW-1], lo};
	assign dn_w = {hi[SW-1], hi} - {x[SW-1], x};
	assign d_w  = {hi[SW-1], hi} - {lo[SW-1], lo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= !mid_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			cls_s0 <= cls;
			up_s0  <= up_w[SW-1:0];
			dn_s0  <= dn_w[SW-1:0];
			d_s0   <= d_w[SW-1:0];
		end
	end

	for (genvar j = 0; j < NSTG; j++) begin : g_div
		logic [SW:0]   t_up;
		logic [SW:0]   t_dn;
		logic [SW:0]   dd;
		logic [FB:0]   qup_prev;
		logic [FB:0]   qdn_prev;
		logic          v_prev;
		tfz_pkg::cls_t cls_prev;
		logic          b_up;
		logic          b_dn;
		logic [SW:0]   n_up;
		logic [SW:0]   n_dn;

		if (j == 0) begin : g_first
			// first quotient bit weighs one: no doubling
			assign t_up     = {1'b0, up_s0};
			assign t_dn     = {1'b0, dn_s0};
			assign dd       = {1'b0, d_s0};
			assign qup_prev = '0;
			assign qdn_prev = '0;
			assign v_prev   = v_s0;
			assign cls_prev = cls_s0;
		end else begin : g_next
			assign t_up     = {rup_sd[j-1], 1'b0};
			assign t_dn     = {rdn_sd[j-1], 1'b0};
			assign dd       = {1'b0, d_sd[j-1]};
			assign qup_prev = qup_sd[j-1];
			assign qdn_prev = qdn_sd[j-1];
			assign v_prev   = v_sd[j-1];
			assign cls_prev = cls_sd[j-1];
		end

		assign b_up = (t_up >= dd);
		assign b_dn = (t_dn >= dd);
		assign n_up = b_up ? (t_up - dd) : t_up;
		assign n_dn = b_dn ? (t_dn - dd) : t_dn;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[j] <= 1'b0;
			end else if (en) begin
				v_sd[j] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cls_sd[j] <= cls_prev;
				qup_sd[j] <= {qup_prev[FB-1:0], b_up};
				qdn_sd[j] <= {qdn_prev[FB-1:0], b_dn};
			end
		end

		if (j < FB) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rup_sd[j] <= n_up[SW-1:0];
					rdn_sd[j] <= n_dn[SW-1:0];
					d_sd[j]   <= dd[SW-1:0];
				end
			end
		end
	end

	assign out_push = en && v_sd[NSTG-1];

	always_comb begin
		out_data = '0;
		case (cls_sd[NSTG-1].kind)
			tfz_pkg::KIND_NB_FULL: begin
				out_data[0] = {1'b1, {FB{1'b0}}};
			end
			tfz_pkg::KIND_PB_FULL: begin
				out_data[NS-1] = {1'b1, {FB{1'b0}}};
			end
			tfz_pkg::KIND_SPAN: begin
				out_data[cls_sd[NSTG-1].idx] = qdn_sd[NSTG-1];
				out_data[tfz_pkg::IDX_W'(cls_sd[NSTG-1].idx + 1'b1)] = qup_sd[NSTG-1];
			end
			default: begin
				out_data = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/triangular_fuzzifier_7set_top.sv =====
// Seven-set triangular fuzzifier, top level.
// Instantiates tfz_front, two tfz_fifo queues and tfz_back; uses tfz_pkg.
//
// Usage:
//   Samples enter through a queue-style port: a transaction completes on a
//   clock edge with push high and full low. Results leave the same way: the
//   oldest result sits on the mu_* ports while empty is low and is taken on
//   an edge with pop high.
//   Breakpoints are written on the cfg_* channel (valid/ready, ready is
//   always high) with index 0..6 for NB..PB; index 7 is dropped. Write them
//   only while no sample is in flight.
// Pipeline and throughput:
//   A result passes, after its sample is accepted, through one classify
//   stage, the two-entry class queue, one distance stage, FRAC_BITS + 1
//   divider stages and the result queue.
//   One sample per cycle is sustained while the result queue is not full;
//   each divider stage resolves one quotient bit.
// Reset: arst_n clears all queues and loads the default breakpoints.
// Stall: when the result queue fills, the divider pipeline holds, the class
//   queue fills behind it and then full rises; nothing is dropped.
`default_nettype none

module triangular_fuzzifier_7set_top #(
	parameter int SAMPLE_WIDTH = tfz_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = tfz_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_value,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [FRAC_BITS:0]                  mu_neg_big,
	output logic [FRAC_BITS:0]                  mu_neg_med,
	output logic [FRAC_BITS:0]                  mu_neg_small,
	output logic [FRAC_BITS:0]                  mu_zero,
	output logic [FRAC_BITS:0]                  mu_pos_small,
	output logic [FRAC_BITS:0]                  mu_pos_med,
	output logic [FRAC_BITS:0]                  mu_pos_big,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tfz_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [SAMPLE_WIDTH-1:0]        cfg_data
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int FB    = FRAC_BITS;
	localparam int NS    = tfz_pkg::SET_COUNT;
	localparam int MID_W = $bits(tfz_pkg::cls_t) + 3 * SW;
	localparam int OUT_W = NS * (FB + 1);

	tfz_pkg::cls_t                 f_cls;
	logic signed [SW-1:0]          f_x;
	logic signed [SW-1:0]          f_lo;
	logic signed [SW-1:0]          f_hi;
	logic                          mid_push;
	logic                          mid_full;
	logic                          mid_pop;
	logic                          mid_empty;
	logic [MID_W-1:0]              mid_wdata;
	logic [MID_W-1:0]              mid_rdata;
	tfz_pkg::cls_t                 b_cls;
	logic signed [SW-1:0]          b_x;
	logic signed [SW-1:0]          b_lo;
	logic signed [SW-1:0]          b_hi;
	logic                          out_push;
	logic                          out_full;
	logic [NS-1:0][FB:0]           out_wdata;
	logic [NS-1:0][FB:0]           out_rdata;

	tfz_front #(
		.SAMPLE_WIDTH(SW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.sample_value(sample_value),
		.full        (full),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mid_full    (mid_full),
		.mid_push    (mid_push),
		.cls         (f_cls),
		.x           (f_x),
		.lo          (f_lo),
		.hi          (f_hi)
	);

	assign mid_wdata = {f_cls, f_x, f_lo, f_hi};
	assign {b_cls, b_x, b_lo, b_hi} = mid_rdata;

	tfz_fifo #(
		.WIDTH(MID_W),
		.DEPTH(tfz_pkg::QUEUE_DEPTH)
	) u_mid_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (mid_push),
		.push_data(mid_wdata),
		.full     (mid_full),
		.pop      (mid_pop),
		.pop_data (mid_rdata),
		.empty    (mid_empty)
	);

	tfz_back #(
		.SAMPLE_WIDTH(SW),
		.FRAC_BITS   (FB)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_empty(mid_empty),
		.mid_pop  (mid_pop),
		.cls      (b_cls),
		.x        (b_x),
		.lo       (b_lo),
		.hi       (b_hi),
		.out_full (out_full),
		.out_push (out_push),
		.out_data (out_wdata)
	);

	tfz_fifo #(
		.WIDTH(OUT_W),
		.DEPTH(tfz_pkg::QUEUE_DEPTH)
	) u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (out_push),
		.push_data(out_wdata),
		.full     (out_full),
		.pop      (pop),
		.pop_data (out_rdata),
		.empty    (empty)
	);

	assign mu_neg_big   = out_rdata[0];
	assign mu_neg_med   = out_rdata[1];
	assign mu_neg_small = out_rdata[2];
	assign mu_zero      = out_rdata[3];
	assign mu_pos_small = out_rdata[4];
	assign mu_pos_med   = out_rdata[5];
	assign mu_pos_big   = out_rdata[6];

endmodule

`default_nettype wire

// ===== test/triangular_fuzzifier_7set_top_test.sv =====
// Testbench for triangular_fuzzifier_7set_top: queue-style sample and result ports,
// breakpoint writes on the cfg channel, self-checking against an in-bench membership model.
// Depends on tfz_pkg and the fuzzifier RTL.

module triangular_fuzzifier_7set_top_test;

	localparam int SW         = tfz_pkg::SAMPLE_WIDTH_DEF;
	localparam int FB         = tfz_pkg::FRAC_BITS_DEF;
	localparam int NS         = tfz_pkg::SET_COUNT;
	localparam int IW         = tfz_pkg::IDX_W;
	localparam int FULL_SCALE = 1 << FB;
	localparam int RAND_ITEMS = 190;
	localparam int HOLD_LEN   = 300;
	localparam int SETTLE     = 30;
	localparam int CYCLE_LIMIT = 250000;

	localparam logic [IW-1:0] REG_UNUSED = 3'd7;
	localparam logic [IW-1:0] CFG_SEQ [NS+1] = '{tfz_pkg::REG_BREAK_NB,
		tfz_pkg::REG_BREAK_NM, tfz_pkg::REG_BREAK_NS, tfz_pkg::REG_BREAK_ZZ,
		tfz_pkg::REG_BREAK_PS, tfz_pkg::REG_BREAK_PM, tfz_pkg::REG_BREAK_PB, REG_UNUSED};

	typedef logic [NS-1:0][FB:0] degrees_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic signed [SW-1:0] sample_value;
	logic                 empty;
	logic                 pop;
	logic [FB:0]          mu_neg_big, mu_neg_med, mu_neg_small, mu_zero;
	logic [FB:0]          mu_pos_small, mu_pos_med, mu_pos_big;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [IW-1:0]        cfg_index;
	logic [SW-1:0]        cfg_data;

	class membership_scoreboard;
		logic signed [SW-1:0] breaks [NS];
		degrees_t expected_degrees [$];
		int mismatches;
		int samples_seen;
		int results_seen;
		int writes_seen;
		string set_names [NS];

		function new();
			for (int i = 0; i < NS; i++)
				breaks[i] = SW'(tfz_pkg::break_reset(i, SW));
			set_names = '{"NB", "NM", "NS", "ZZ", "PS", "PM", "PB"};
			mismatches = 0;
			samples_seen = 0;
			results_seen = 0;
			writes_seen = 0;
		endfunction

		function void set_break(logic [IW-1:0] idx, logic [SW-1:0] data);
			writes_seen++;
			if (idx < NS)
				breaks[idx] = data;
		endfunction

		// membership of every set for one crisp sample
		function degrees_t degrees_for(logic signed [SW-1:0] x);
			degrees_t mu;
			longint xv, lo, hi, span;
			bit done;
			mu = '0;
			xv = x;
			done = 0;
			if (xv <= longint'(breaks[0])) begin
				mu[0] = (FB+1)'(FULL_SCALE);
				done = 1;
			end
			for (int i = 0; i < NS - 1; i++) begin
				lo = breaks[i];
				hi = breaks[i+1];
				if (!done && lo <= xv && xv < hi) begin
					span = hi - lo;
					mu[i]   = (FB+1)'(((hi - xv) << FB) / span);
					mu[i+1] = (FB+1)'(((xv - lo) << FB) / span);
					done = 1;
				end
			end
			if (!done)
				mu[NS-1] = (FB+1)'(FULL_SCALE);
			return mu;
		endfunction

		function void note_sample(logic signed [SW-1:0] x);
			samples_seen++;
			expected_degrees.push_back(degrees_for(x));
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_degrees(degrees_t got);
			degrees_t want;
			results_seen++;
			if (expected_degrees.size() == 0) begin
				report($sformatf("result %0d arrived with no sample outstanding",
					results_seen));
			end else begin
				want = expected_degrees.pop_front();
				for (int i = 0; i < NS; i++)
					if (got[i] !== want[i])
						report($sformatf("result %0d set %s: got %0d want %0d",
							results_seen, set_names[i], got[i], want[i]));
			end
		endtask

		function int outstanding();
			return expected_degrees.size();
		endfunction
	endclass

	membership_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int hold_left;
	int cycle_count;
	int levels [NS];
	int directed_samples [21];

	triangular_fuzzifier_7set_top DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .sample_value(sample_value),
		.empty(empty), .pop(pop),
		.mu_neg_big(mu_neg_big), .mu_neg_med(mu_neg_med), .mu_neg_small(mu_neg_small),
		.mu_zero(mu_zero), .mu_pos_small(mu_pos_small), .mu_pos_med(mu_pos_med),
		.mu_pos_big(mu_pos_big),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("triangular_fuzzifier_7set_top verification failed");
			$finish;
		end
	end

	// monitor: every transaction seen on the pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.set_break(cfg_index, cfg_data);
			if (push && !full)
				board.note_sample(sample_value);
			if (pop && !empty)
				board.check_degrees({mu_pos_big, mu_pos_med, mu_pos_small, mu_zero,
					mu_neg_small, mu_neg_med, mu_neg_big});
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_LEN;
			end
			if (!arst_n) begin
				pop <= 0;
			end else if (hold_left > 0) begin
				pop <= 0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// idle a random number of cycles, then offer the sample until taken
	task automatic send_sample(input logic signed [SW-1:0] x);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		sample_value <= x;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// write all seven breakpoints from levels, then poke the unused index
	task automatic load_breaks();
		for (int i = 0; i <= NS; i++) begin
			cfg_valid <= 1;
			cfg_index <= CFG_SEQ[i];
			cfg_data <= (i < NS) ? SW'(levels[i]) : SW'($urandom);
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		push <= 0;
		while (board.outstanding() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		int sel, i, lo, hi;
		sel = $urandom_range(0, 9);
		i = $urandom_range(0, NS - 2);
		lo = board.breaks[i];
		hi = board.breaks[i+1];
		if (sel < 4)
			return SW'(int'(board.breaks[$urandom_range(0, NS - 1)]) +
				int'($urandom_range(0, 16)) - 8);
		if (sel < 7 && hi > lo)
			return SW'(lo + int'($urandom_range(0, hi - lo - 1)));
		if (sel == 7)
			case ($urandom_range(0, 3))
				0: return SW'(-32768);
				1: return SW'(-32767);
				2: return SW'(32766);
				default: return SW'(32767);
			endcase
		return SW'($urandom);
	endfunction

	initial begin
		int sorted_levels [$];
		int base;
		board = new();
		arst_n = 0;
		push = 0;
		sample_value = 0;
		pop = 0;
		cfg_valid = 0;
		cfg_index = tfz_pkg::REG_BREAK_NB;
		cfg_data = 0;
		hold_req = 0;
		cycle_count = 0;
		send_idle_pct = 16;
		recv_idle_pct = 54;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// default peaks: range ends, the peaks apart from 16384, some of their neighbors and points inside spans
		directed_samples = '{-32768, 32767, -24577, -24576, -24575, -20480, -16385, -16384,
			-8192, -1, 0, 1, 8191, 8192, 12345, 16383, 24575, 24576, 24577, -21846, 21845};
		foreach (directed_samples[k])
			send_sample(SW'(directed_samples[k]));
		wait_drained();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: levels = '{-32768, -21846, -10923, 0, 10922, 21845, 32767};
				1: begin
					sorted_levels.delete();
					for (int i = 0; i < NS; i++)
						sorted_levels.push_back(int'($urandom_range(0, 65535)) - 32768);
					sorted_levels.sort();
					foreach (levels[i])
						levels[i] = sorted_levels[i];
				end
				2: begin
					// one-step spacing: every span is a single code
					base = int'($urandom_range(0, 65529)) - 32768;
					foreach (levels[i])
						levels[i] = base + i;
				end
				3: levels = '{5000, -5000, -5000, 0, 0, 12000, 12000};
				4: foreach (levels[i])
					levels[i] = int'($urandom_range(0, 65535)) - 32768;
				default: levels = '{-24576, -16384, -8192, 0, 8192, 16384, 24576};
			endcase
			send_idle_pct = (phase < 2) ? 16 : (phase < 4) ? 54 : 0;
			recv_idle_pct = (phase < 2) ? 54 : (phase < 4) ? 16 : 0;
			load_breaks();
			if (phase == 1)
				hold_req = 1;
			repeat (RAND_ITEMS) send_sample(pick_sample());
			wait_drained();
		end

		$display("covered %0d samples and %0d results over %0d breakpoint writes",
			board.samples_seen, board.results_seen, board.writes_seen);
		$display("breakpoint layouts: defaults, full span, sorted random, one-step,",
			" duplicate and reversed, unsorted random; %0d mismatches", board.mismatches);
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("triangular_fuzzifier_7set_top verification clean");
		end else begin
			$display("triangular_fuzzifier_7set_top verification failed");
		end
		$finish;
	end

endmodule

// ===== triangular_fuzzifier_7set_top.f =====
design/tfz_pkg.sv
design/tfz_fifo.sv
design/tfz_front.sv
design/tfz_back.sv
design/triangular_fuzzifier_7set_top.sv
test/triangular_fuzzifier_7set_top_test.sv
